>>> sv/rlpm_pkg.sv
// ----------------------------------------------------------------------------
// rlpm_pkg
// Shared types and constants for the register list patch merger.
// ----------------------------------------------------------------------------
package rlpm_pkg;

  localparam int EDIT_DEPTH = 32;
  localparam int BASE_MAX   = 1024;

  localparam int EDIT_AW  = (EDIT_DEPTH > 1) ? $clog2(EDIT_DEPTH) : 1;
  localparam int EDIT_CW  = $clog2(EDIT_DEPTH + 1);
  localparam int POS_W    = 10;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 11;
  localparam int CNT_MAX  = 2 * BASE_MAX - 1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_BASE = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REPLACE = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_ALT     = 2'd3
  } kind_e;

  typedef enum logic {
    RES_PAIR    = 1'b0,
    RES_TRAILER = 1'b1
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_END,
    ST_FLUSH,
    ST_TRAIL
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [1:0]        kind;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] val;
  } edit_entry_t;

  typedef struct packed {
    logic               we;
    logic [EDIT_AW-1:0] waddr;
    edit_entry_t        wdata;
    logic [EDIT_AW-1:0] raddr;
  } mem_req_t;

  // Saturating counter step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    if (c < CNT_W'(CNT_MAX)) begin
      return c + CNT_W'(1);
    end
    return CNT_W'(CNT_MAX);
  endfunction

endpackage

>>> sv/rlpm_edit_mem.sv
// ----------------------------------------------------------------------------
// rlpm_edit_mem
// Edit table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rlpm_edit_mem import rlpm_pkg::*; (
  input  logic        clk_i,
  input  mem_req_t    req_i,
  output edit_entry_t rdata_o
);

  edit_entry_t mem_q [EDIT_DEPTH];
  edit_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rlpm_ctrl.sv
// ----------------------------------------------------------------------------
// rlpm_ctrl
// Merge sequencer: walks the edit table, merges base pairs, stages results.
// ----------------------------------------------------------------------------
module rlpm_ctrl import rlpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        cmd_i,
  input  logic [1:0]        edit_kind_i,
  input  logic [POS_W-1:0]  edit_position_i,
  input  logic [DATA_W-1:0] reg_address_i,
  input  logic [DATA_W-1:0] reg_value_i,
  input  edit_entry_t       rdata_i,
  output mem_req_t          req_o,
  output logic              busy_o,
  output logic              strobe_o,
  output logic              result_kind_o,
  output logic [DATA_W-1:0] out_address_o,
  output logic [DATA_W-1:0] out_value_o,
  output logic [CNT_W-1:0]  out_index_o,
  output logic              last_o
);

  state_e state_q, state_d;

  logic [EDIT_CW-1:0] loaded_q, loaded_d;
  logic [EDIT_CW-1:0] next_q, next_d;
  logic [CNT_W-1:0]   bc_q, bc_d;
  logic [CNT_W-1:0]   emit_q, emit_d;

  logic [DATA_W-1:0]  base_addr_q, base_addr_d;
  logic [DATA_W-1:0]  base_val_q, base_val_d;

  // one-deep hold so the final result of an item can carry last
  logic               hold_v_q, hold_v_d;
  logic [DATA_W-1:0]  hold_addr_q, hold_addr_d;
  logic [DATA_W-1:0]  hold_val_q, hold_val_d;
  logic [CNT_W-1:0]   hold_idx_q, hold_idx_d;

  logic               stb_q, stb_d;
  logic               last_q, last_d;
  logic               rkind_q, rkind_d;
  logic [DATA_W-1:0]  oaddr_q, oaddr_d;
  logic [DATA_W-1:0]  oval_q, oval_d;
  logic [CNT_W-1:0]   oidx_q, oidx_d;

  logic               have_entry, ent_due, ent_ins, ent_del;
  logic [EDIT_CW-1:0] next_inc;
  logic               gen;
  logic [DATA_W-1:0]  gen_addr, gen_val;

  assign have_entry = next_q < loaded_q;
  assign ent_due    = have_entry && ({1'b0, rdata_i.pos} <= bc_q);
  assign ent_ins    = rdata_i.kind == KIND_INSERT;
  assign ent_del    = rdata_i.kind == KIND_DELETE;
  assign next_inc   = next_q + EDIT_CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_BASE: state_d = ST_BASE;
            CMD_END:  state_d = ST_END;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_BASE: begin
        if (!(ent_due && ent_ins)) begin
          // a second pending result goes out through ST_FLUSH
          if (hold_v_q && (!ent_due || !ent_del)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (!have_entry) begin
          state_d = hold_v_q ? ST_TRAIL : ST_IDLE;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      ST_TRAIL: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    loaded_d    = loaded_q;
    next_d      = next_q;
    bc_d        = bc_q;
    emit_d      = emit_q;
    base_addr_d = base_addr_q;
    base_val_d  = base_val_q;
    hold_v_d    = hold_v_q;
    hold_addr_d = hold_addr_q;
    hold_val_d  = hold_val_q;
    hold_idx_d  = hold_idx_q;
    stb_d       = 1'b0;
    last_d      = 1'b0;
    rkind_d     = RES_PAIR;
    oaddr_d     = hold_addr_q;
    oval_d      = hold_val_q;
    oidx_d      = hold_idx_q;
    gen         = 1'b0;
    gen_addr    = rdata_i.addr;
    gen_val     = rdata_i.val;

    req_o.we          = 1'b0;
    req_o.waddr       = loaded_q[EDIT_AW-1:0];
    req_o.wdata.pos   = edit_position_i;
    req_o.wdata.kind  = edit_kind_i;
    req_o.wdata.addr  = reg_address_i;
    req_o.wdata.val   = reg_value_i;
    req_o.raddr       = next_q[EDIT_AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_LOAD: begin
              if (loaded_q < EDIT_CW'(EDIT_DEPTH)) begin
                req_o.we = 1'b1;
                loaded_d = loaded_q + EDIT_CW'(1);
              end
            end
            CMD_BASE: begin
              base_addr_d = reg_address_i;
              base_val_d  = reg_value_i;
            end
            default: ;
          endcase
        end
      end

      ST_BASE: begin
        if (ent_due && ent_ins) begin
          gen         = 1'b1;
          next_d      = next_inc;
          req_o.raddr = next_inc[EDIT_AW-1:0];
          stb_d       = hold_v_q;
          hold_v_d    = 1'b1;
          hold_addr_d = gen_addr;
          hold_val_d  = gen_val;
          hold_idx_d  = emit_q;
        end else begin
          bc_d = sat_inc(bc_q);
          if (ent_due) begin
            gen    = !ent_del;
            next_d = next_inc;
          end else begin
            gen      = 1'b1;
            gen_addr = base_addr_q;
            gen_val  = base_val_q;
          end
          if (gen && hold_v_q) begin
            stb_d       = 1'b1;
            hold_addr_d = gen_addr;
            hold_val_d  = gen_val;
            hold_idx_d  = emit_q;
          end else if (gen) begin
            stb_d   = 1'b1;
            last_d  = 1'b1;
            oaddr_d = gen_addr;
            oval_d  = gen_val;
            oidx_d  = emit_q;
          end else if (hold_v_q) begin
            stb_d    = 1'b1;
            last_d   = 1'b1;
            hold_v_d = 1'b0;
          end
        end
      end

      ST_END: begin
        if (have_entry) begin
          gen         = !ent_del;
          next_d      = next_inc;
          req_o.raddr = next_inc[EDIT_AW-1:0];
          if (gen) begin
            stb_d       = hold_v_q;
            hold_v_d    = 1'b1;
            hold_addr_d = gen_addr;
            hold_val_d  = gen_val;
            hold_idx_d  = emit_q;
          end
        end else if (hold_v_q) begin
          stb_d    = 1'b1;
          hold_v_d = 1'b0;
        end else begin
          stb_d    = 1'b1;
          last_d   = 1'b1;
          rkind_d  = RES_TRAILER;
          oaddr_d  = '0;
          oval_d   = '0;
          oidx_d   = emit_q;
          loaded_d = '0;
          next_d   = '0;
          bc_d     = '0;
        end
      end

      ST_FLUSH: begin
        stb_d    = 1'b1;
        last_d   = 1'b1;
        hold_v_d = 1'b0;
      end

      ST_TRAIL: begin
        stb_d    = 1'b1;
        last_d   = 1'b1;
        rkind_d  = RES_TRAILER;
        oaddr_d  = '0;
        oval_d   = '0;
        oidx_d   = emit_q;
        loaded_d = '0;
        next_d   = '0;
        bc_d     = '0;
      end

      default: ;
    endcase

    if (gen) begin
      emit_d = sat_inc(emit_q);
    end else if (rkind_d == RES_TRAILER && stb_d) begin
      emit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= '0;
      next_q   <= '0;
      bc_q     <= '0;
      emit_q   <= '0;
      hold_v_q <= 1'b0;
      stb_q    <= 1'b0;
      last_q   <= 1'b0;
      rkind_q  <= RES_PAIR;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      next_q   <= next_d;
      bc_q     <= bc_d;
      emit_q   <= emit_d;
      hold_v_q <= hold_v_d;
      stb_q    <= stb_d;
      last_q   <= last_d;
      rkind_q  <= rkind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_addr_q <= base_addr_d;
    base_val_q  <= base_val_d;
    hold_addr_q <= hold_addr_d;
    hold_val_q  <= hold_val_d;
    hold_idx_q  <= hold_idx_d;
    oaddr_q     <= oaddr_d;
    oval_q      <= oval_d;
    oidx_q      <= oidx_d;
  end

  assign busy_o        = state_q != ST_IDLE;
  assign strobe_o      = stb_q;
  assign result_kind_o = rkind_q;
  assign out_address_o = oaddr_q;
  assign out_value_o   = oval_q;
  assign out_index_o   = oidx_q;
  assign last_o        = last_q;

endmodule

>>> sv/register_list_patch_merger_unit.sv
// Load writes one edit into the table while it is not full. Base pair: applied
// insert edits go out first, then the base pair is replaced, deleted or passed on.
// End of list: the remaining edits are drained, then the trailer follows.
// Results are registered before they show on the ports.
// Asynchronous active-low reset clears all counters and control; the edit table
// holds no reset and its entries are only used below the loaded count.
// ----------------------------------------------------------------------------
// register_list_patch_merger_unit
// Merges a sorted edit table into a stream of base register pairs.
// ----------------------------------------------------------------------------
module register_list_patch_merger_unit import rlpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        cmd_i,
  input  logic [1:0]        edit_kind_i,
  input  logic [POS_W-1:0]  edit_position_i,
  input  logic [DATA_W-1:0] reg_address_i,
  input  logic [DATA_W-1:0] reg_value_i,
  output logic              strobe_o,
  output logic              result_kind_o,
  output logic [DATA_W-1:0] out_address_o,
  output logic [DATA_W-1:0] out_value_o,
  output logic [CNT_W-1:0]  out_index_o,
  output logic              last_o
);

  mem_req_t    mem_req;
  edit_entry_t mem_rdata;

  rlpm_edit_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rlpm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .cmd_i           (cmd_i),
    .edit_kind_i     (edit_kind_i),
    .edit_position_i (edit_position_i),
    .reg_address_i   (reg_address_i),
    .reg_value_i     (reg_value_i),
    .rdata_i         (mem_rdata),
    .req_o           (mem_req),
    .busy_o          (busy_o),
    .strobe_o        (strobe_o),
    .result_kind_o   (result_kind_o),
    .out_address_o   (out_address_o),
    .out_value_o     (out_value_o),
    .out_index_o     (out_index_o),
    .last_o          (last_o)
  );

endmodule

>>> sv/rlpm_checker.sv
// ----------------------------------------------------------------------------
// rlpm_checker
// Port-level checks for the merger, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rlpm_checker import rlpm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [1:0]        cmd_i,
  input logic              strobe_o,
  input logic              result_kind_o,
  input logic [DATA_W-1:0] out_address_o,
  input logic [DATA_W-1:0] out_value_o,
  input logic              last_o
);

  logic load_xfer, end_xfer;

  assign load_xfer = start_i && !busy_o && (cmd_i == CMD_LOAD);
  assign end_xfer  = start_i && !busy_o && (cmd_i == CMD_END);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> (!busy_o && !strobe_o))
    else $error("busy or strobe during reset");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> (!busy_o && !strobe_o))
    else $error("load transfer produced a result or stall");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_xfer |=> busy_o)
    else $error("end of list did not start the drain");

  a_trailer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_kind_o) |-> (last_o && out_address_o == '0 && out_value_o == '0))
    else $error("malformed trailer");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("result right after a final result");

endmodule

bind register_list_patch_merger_unit rlpm_checker u_rlpm_checker (.*);
